// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on the rising edge, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types, constants and helper functions of the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    typedef logic [31:0] t_cp;
    typedef logic [2:0]  t_trails;
    typedef logic [15:0] t_unit;

    typedef struct packed {
        logic valid;
        t_cp  cp;
    } t_cp_xfer;

    typedef enum logic {
        BACK_FIRST,
        BACK_SECOND
    } t_back_state;

    localparam t_cp     SEQ_OFS_0    = 32'h0000_0000;
    localparam t_cp     SEQ_OFS_1    = 32'h0000_3080;
    localparam t_cp     SEQ_OFS_2    = 32'h000E_2080;
    localparam t_cp     SEQ_OFS_3    = 32'h03C8_2080;
    localparam t_cp     SEQ_OFS_4    = 32'hFA08_2080;
    localparam t_cp     SEQ_OFS_5    = 32'h8208_2080;

    localparam t_unit   UNIT_REPLACE = 16'hFFFD;
    localparam t_cp     CP_MAX       = 32'h0010_FFFF;
    localparam t_cp     CP_SUPP_BASE = 32'h0001_0000;
    localparam logic [5:0] SUR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SUR_LOW_TAG  = 6'b110111;
    localparam logic [4:0] SUR_RANGE_TAG = 5'b11011;

    function automatic t_trails lead_trails(input logic [7:0] b);
        t_trails t;
        case (b) inside
            [8'h00:8'hBF]: t = 3'd0;
            [8'hC0:8'hDF]: t = 3'd1;
            [8'hE0:8'hEF]: t = 3'd2;
            [8'hF0:8'hF7]: t = 3'd3;
            [8'hF8:8'hFB]: t = 3'd4;
            default:       t = 3'd5;
        endcase
        return t;
    endfunction

    function automatic t_cp seq_offset(input t_trails t);
        t_cp o;
        case (t)
            3'd1:    o = SEQ_OFS_1;
            3'd2:    o = SEQ_OFS_2;
            3'd3:    o = SEQ_OFS_3;
            3'd4:    o = SEQ_OFS_4;
            3'd5:    o = SEQ_OFS_5;
            default: o = SEQ_OFS_0;
        endcase
        return o;
    endfunction

endpackage

// ===== rtl/core/u8u16_front.sv =====
// ----------------------------------------------------------------------------
// u8u16_front
// Accept bytes, track the sequence length and build code points.
// ----------------------------------------------------------------------------
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_ready,
    output t_cp_xfer   o_push
);

    t_cp     r_acc,   n_acc;
    t_trails r_left,  n_left;
    t_trails r_seq,   n_seq;
    logic    accept;
    logic    done;

    assign accept = i_valid && i_ready;

    always_comb begin
        if (r_left == 3'd0) begin
            n_seq  = lead_trails(i_byte);
            n_left = n_seq;
            n_acc  = {24'd0, i_byte};
        end else begin
            n_seq  = r_seq;
            n_left = r_left - 3'd1;
            n_acc  = {r_acc[25:0], 6'd0} + {24'd0, i_byte};
        end
        done = (n_left == 3'd0);
    end

    assign o_push.valid = accept && done;
    assign o_push.cp    = n_acc - seq_offset(n_seq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_left <= '0;
            r_seq  <= '0;
        end else if (accept) begin
            if (done || i_last) begin
                r_acc  <= '0;
                r_left <= '0;
                r_seq  <= '0;
            end else begin
                r_acc  <= n_acc;
                r_left <= n_left;
                r_seq  <= n_seq;
            end
        end
    end

endmodule

// ===== rtl/core/u8u16_queue.sv =====
// ----------------------------------------------------------------------------
// u8u16_queue
// Short code point queue between front and back.
// ----------------------------------------------------------------------------
module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cp_xfer i_push,
    input  logic     i_pop,
    output t_cp_xfer o_head,
    output logic     o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cp           r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_pop;

    assign do_pop = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cp    = r_mem[r_rd];
    assign o_full       = (r_cnt == CNT_FULL);

    always_comb begin
        n_wr  = i_push.valid ? ((r_wr == PTR_LAST) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd  = do_pop ? ((r_rd == PTR_LAST) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt;
        if (i_push.valid && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push.valid && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.cp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/u8u16_back.sv =====
// ----------------------------------------------------------------------------
// u8u16_back
// Classify queued code points and emit UTF-16 code units.
// ----------------------------------------------------------------------------
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cp_xfer i_head,
    output logic     o_pop,
    output logic     o_valid,
    input  logic     i_ready,
    output t_unit    o_unit,
    output logic     o_last
);

    t_back_state r_state, n_state;
    logic        r_valid;
    t_unit       r_unit;
    logic        r_last;
    logic        load;
    logic        neg;
    logic        bmp;
    logic        sur;
    logic        pair;
    logic [19:0] supp;
    t_cp         supp_full;
    t_unit       n_unit;
    logic        n_last;

    assign load = !r_valid || i_ready;

    always_comb begin
        neg       = i_head.cp[31];
        bmp       = neg || (i_head.cp[31:16] == 16'd0);
        sur       = !neg && (i_head.cp[31:16] == 16'd0)
                    && (i_head.cp[15:11] == SUR_RANGE_TAG);
        pair      = !bmp && (i_head.cp <= CP_MAX);
        supp_full = i_head.cp - CP_SUPP_BASE;
        supp      = supp_full[19:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BACK_FIRST: begin
                if (load && i_head.valid && pair) begin
                    n_state = BACK_SECOND;
                end
            end
            BACK_SECOND: begin
                if (load) begin
                    n_state = BACK_FIRST;
                end
            end
            default: n_state = BACK_FIRST;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        n_unit = UNIT_REPLACE;
        n_last = 1'b1;
        case (r_state)
            BACK_FIRST: begin
                o_pop = load && i_head.valid && !pair;
                if (pair) begin
                    n_unit = {SUR_HIGH_TAG, supp[19:10]};
                    n_last = 1'b0;
                end else if (bmp && !sur) begin
                    n_unit = i_head.cp[15:0];
                end
            end
            BACK_SECOND: begin
                o_pop  = load;
                n_unit = {SUR_LOW_TAG, supp[9:0]};
            end
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BACK_FIRST;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_valid <= i_head.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_unit <= n_unit;
            r_last <= n_last;
        end
    end

    assign o_valid = r_valid;
    assign o_unit  = r_unit;
    assign o_last  = r_last;

endmodule

// ===== rtl/core/utf8_to_utf16_decoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_core
// UTF-8 byte stream in, UTF-16 code unit stream out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle. The front builds each code point as bytes
// arrive and pushes it into a queue of DEPTH entries once its last byte is
// taken; the back drains the queue into a registered output, one code unit
// per cycle while the receiver is ready. A surrogate pair yields two code
// units, so input stalls only when the queue fills. A code point reaches
// the output through the queue and the output register. tlast on input
// drops an unfinished sequence; tlast on output marks the final code unit
// caused by one input byte (low on the high half of a pair).
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_core
    import u8u16_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tlast
);

    t_cp_xfer push;
    t_cp_xfer head;
    logic     pop;
    logic     full;

    assign s_axis_tready = !full;

    u8u16_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_ready (s_axis_tready),
        .o_push  (push)
    );

    u8u16_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    u8u16_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_unit  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

// ===== rtl/core/u8u16_checker.sv =====
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks of the UTF-8 to UTF-16 decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8u16_checker
    import u8u16_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "stalled output transaction changed")

    `ASSERT_SAME(a_high_half, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast,
        m_axis_tdata[15:10] == SUR_HIGH_TAG, "non-final unit is not a high surrogate")

    `ASSERT_NEXT(a_low_follows, i_clk, i_rst_n, out_xfer && !m_axis_tlast,
        m_axis_tvalid && m_axis_tlast && (m_axis_tdata[15:10] == SUR_LOW_TAG),
        "high surrogate not followed by low surrogate")

    `ASSERT_NEXT(a_idle_no_out, i_clk, i_rst_n, !in_xfer && !m_axis_tvalid && s_axis_tready,
        !m_axis_tvalid || $past(s_axis_tvalid, 2) || !s_axis_tready,
        "output appeared without queued work")

endmodule

bind utf8_to_utf16_decoder_core u8u16_checker u_u8u16_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to UTF-16 decoder core.
// ----------------------------------------------------------------------------
// Bytes go in on the slave stream and code units come out on the master
// stream. A scoreboard decodes every accepted byte on its own and holds the
// code units it expects. Each output transaction is checked against the
// oldest of them. A short directed run comes first. It covers lone
// surrogates, surrogate pairs, out-of-range and negative values, five-byte
// and six-byte leads, and sequences cut off or completed by tlast. Random
// sequences follow, mostly well formed with random content, with some noise
// bytes mixed in. Both sides idle at random, and there are stretches with no
// idling.
// ----------------------------------------------------------------------------
module tb;
    import u8u16_pkg::*;

    class utf16_scoreboard;
        typedef struct packed {
            t_unit code_unit;
            logic  last_unit;
        } t_expected;

        localparam t_cp SUR_LO_FIRST  = 32'h0000_D800;
        localparam t_cp SUR_HI_LAST   = 32'h0000_DFFF;
        localparam t_unit HIGH_BASE   = 16'hD800;
        localparam t_unit LOW_BASE    = 16'hDC00;

        t_cp       acc;
        t_trails   trails_left;
        t_trails   seq_trails;
        t_cp       offsets[6];
        t_expected units_q[$];
        int        errors;

        function new();
            offsets[0] = SEQ_OFS_0;
            offsets[1] = SEQ_OFS_1;
            offsets[2] = SEQ_OFS_2;
            offsets[3] = SEQ_OFS_3;
            offsets[4] = SEQ_OFS_4;
            offsets[5] = SEQ_OFS_5;
            errors = 0;
            clear();
        endfunction

        function void clear();
            acc = '0;
            trails_left = '0;
            seq_trails = '0;
        endfunction

        function int pending();
            return units_q.size();
        endfunction

        function t_trails lead_count(input logic [7:0] b);
            int ones;
            ones = 0;
            while (ones < 8 && b[7 - ones])
                ones++;
            if (ones < 2)
                return 3'd0;
            return (ones > 6) ? 3'd5 : t_trails'(ones - 1);
        endfunction

        function void push_unit(input t_unit code, input logic last);
            t_expected e;
            e.code_unit = code;
            e.last_unit = last;
            units_q.push_back(e);
        endfunction

        // decode one accepted byte and queue the code units it yields
        function void note_byte(input logic [7:0] b, input logic eoi);
            t_cp v;
            if (trails_left == 0) begin
                seq_trails = lead_count(b);
                trails_left = seq_trails;
                acc = {24'd0, b};
            end else begin
                acc = (acc << 6) + {24'd0, b};
                trails_left = trails_left - 3'd1;
            end
            if (trails_left != 0) begin
                if (eoi)
                    clear();
                return;
            end
            v = acc - offsets[seq_trails];
            clear();
            if (v[31] || v <= 32'h0000_FFFF) begin
                if (!v[31] && v >= SUR_LO_FIRST && v <= SUR_HI_LAST)
                    push_unit(UNIT_REPLACE, 1'b1);
                else
                    push_unit(v[15:0], 1'b1);
            end else if (v > CP_MAX) begin
                push_unit(UNIT_REPLACE, 1'b1);
            end else begin
                v = v - CP_SUPP_BASE;
                push_unit(HIGH_BASE + {6'd0, v[19:10]}, 1'b0);
                push_unit(LOW_BASE + {6'd0, v[9:0]}, 1'b1);
            end
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_unit(input t_unit code, input logic last);
            t_expected e;
            if (units_q.size() == 0) begin
                report($sformatf("unexpected code unit %h last %b", code, last));
                return;
            end
            e = units_q.pop_front();
            if (code !== e.code_unit)
                report($sformatf("code unit %h, want %h", code, e.code_unit));
            if (last !== e.last_unit)
                report($sformatf("tlast %b on unit %h, want %b", last, code, e.last_unit));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] byte_value
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [15:0] code_unit
    logic        m_axis_tlast;

    utf16_scoreboard sb = new();

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_stall = 0;
    int random_bytes = 0;

    utf8_to_utf16_decoder_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15)
            return $urandom_range(1, 3);
        if (r < 19)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready = 1'b0;
        end else if (rx_stall > 0) begin
            m_axis_tready = 1'b0;
            rx_stall--;
        end else begin
            m_axis_tready = 1'b1;
            if (rx_idle && $urandom_range(0, 3) == 0)
                rx_stall = idle_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_unit(m_axis_tdata, m_axis_tlast);
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        gap = 0;
        if (tx_idle && $urandom_range(0, 3) == 0)
            gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        s_axis_tlast = eoi;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_byte(b, eoi);
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input logic [7:0] seq_q[$], input logic eoi_at_end);
        foreach (seq_q[i])
            send_byte(seq_q[i], eoi_at_end && i == seq_q.size() - 1);
    endtask

    // hold the input until every queued code unit has come out
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random_seq();
        int r;
        int n;
        logic [7:0] b;
        logic eoi;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
            random_bytes++;
            return;
        end
        r = $urandom_range(0, 99);
        n = (r < 25) ? 1 : (r < 45) ? 2 : (r < 65) ? 3 : (r < 85) ? 4 : (r < 93) ? 5 : 6;
        for (int i = 0; i < n; i++) begin
            if (i == 0) begin
                case (n)
                    1: b = 8'($urandom_range(8'h00, 8'hBF));
                    2: b = 8'($urandom_range(8'hC0, 8'hDF));
                    3: b = 8'($urandom_range(8'hE0, 8'hEF));
                    4: b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'hF0, 8'hF4))
                                                       : 8'($urandom_range(8'hF0, 8'hF7));
                    5: b = 8'($urandom_range(8'hF8, 8'hFB));
                    default: b = 8'($urandom_range(8'hFC, 8'hFF));
                endcase
            end else if ($urandom_range(0, 9) == 0) begin
                b = 8'($urandom_range(0, 255));
            end else begin
                b = 8'h80 | 8'($urandom_range(0, 63));
            end
            eoi = ($urandom_range(0, 59) == 0) || (i == n - 1 && $urandom_range(0, 14) == 0);
            send_byte(b, eoi);
            random_bytes++;
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_bytes({8'h00}, 1'b0);
        send_bytes({8'hBF}, 1'b0);
        send_bytes({8'hED, 8'hA0, 8'h80}, 1'b0);
        send_bytes({8'hF0, 8'h9F, 8'h98, 8'h80}, 1'b0);
        send_bytes({8'hF4, 8'h90, 8'h80, 8'h80}, 1'b0);
        send_bytes({8'hF8, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0);
        send_bytes({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
        send_bytes({8'hE2, 8'h82}, 1'b1);
        send_bytes({8'hC3, 8'hA9}, 1'b1);
        drain();

        for (int phase = 0; random_bytes < 1420; phase++) begin
            tx_idle = (phase % 4) != 0;
            rx_idle = (phase % 3) != 0;
            while (random_bytes < (phase + 1) * 180 && random_bytes < 1420)
                send_random_seq();
            if (phase == 3)
                drain();
        end

        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
